>>> rtl/forth_stack_execution_unit_macros.svh
// assertion helpers shared by the rtl
`ifndef FORTH_STACK_EXECUTION_UNIT_MACROS_SVH
`define FORTH_STACK_EXECUTION_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FSX_ASSERT_NOW(lbl, pre, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (prop)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define FSX_ASSERT_NEXT(lbl, pre, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (prop)) \
      else $error(msg);

`endif

>>> rtl/fsx_pkg.sv
`default_nettype none
package fsx_pkg;

   localparam int STACK_CELLS = 1024;
   localparam int CELL_BYTES  = 8;
   localparam int ADDR_W      = $clog2(STACK_CELLS);
   localparam int CNT_W       = 11;
   localparam int CELL_W      = 64;

   typedef enum logic [5:0] {
      OP_DROP = 6'd0, OP_SWAP, OP_DUP, OP_OVER, OP_ROT, OP_NROT, OP_2DROP, OP_2DUP,
      OP_2SWAP, OP_QDUP, OP_INC, OP_DEC, OP_CELLP, OP_CELLM, OP_ADD, OP_SUB, OP_MUL,
      OP_DIVMOD, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE, OP_ZEQ, OP_ZNE, OP_ZLT,
      OP_ZGT, OP_ZLE, OP_ZGE, OP_AND, OP_OR, OP_XOR, OP_INVERT, OP_LIT, OP_TOR,
      OP_RFROM, OP_RDROP
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIVZ  = 2'd3
   } status_type;

   // request to the shared adder
   typedef struct packed {
      logic [CELL_W:0] a;
      logic [CELL_W:0] b;
      logic            sub;
   } add_req_type;

   // cells an op needs on the data stack
   function automatic logic [2:0] need_of(logic [5:0] op);
      logic [2:0] n;
      case (op) inside
         OP_DROP, OP_DUP, OP_QDUP, [OP_INC:OP_CELLM], [OP_ZEQ:OP_ZGE], OP_INVERT,
         OP_TOR:
            n = 3'd1;
         OP_SWAP, OP_OVER, OP_2DROP, OP_2DUP, [OP_ADD:OP_GE], [OP_AND:OP_XOR]:
            n = 3'd2;
         OP_ROT, OP_NROT:
            n = 3'd3;
         OP_2SWAP:
            n = 3'd4;
         default:
            n = 3'd0;
      endcase
      return n;
   endfunction

   // change of data stack depth
   function automatic logic signed [2:0] grow_of(logic [5:0] op);
      logic signed [2:0] g;
      case (op) inside
         OP_DROP, OP_ADD, OP_SUB, OP_MUL, [OP_EQ:OP_GE], [OP_AND:OP_XOR], OP_TOR:
            g = -3'sd1;
         OP_DUP, OP_OVER, OP_QDUP, OP_LIT, OP_RFROM:
            g = 3'sd1;
         OP_2DUP:
            g = 3'sd2;
         OP_2DROP:
            g = -3'sd2;
         default:
            g = 3'sd0;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

>>> rtl/fsx_ram.sv
`default_nettype none
module fsx_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/fsx_alu.sv
`default_nettype none
module fsx_alu
   import fsx_pkg::*;
(
   input  wire add_req_type       req,
   output logic [CELL_W+1:0]      sum
);

   // bit CELL_W+1 is the carry out; on subtract it means no borrow
   assign sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
              + {{(CELL_W+1){1'b0}}, req.sub};

endmodule
`default_nettype wire

>>> rtl/forth_stack_execution_unit.sv
// sequence: shuffles, logic, add and literal ops run operand reads, check, execute,
// write-back and a top reread; mul and /mod iterate on the shared adder before write-back;
// a failed check goes straight to the top reread
// throughput: one transaction at a time, the next one can be accepted in the cycle after the result
// leaves; mul and /mod run 64 steps of the shared adder
// reset: synchronous, clears both depths and the sequencer; ram contents are not cleared
`default_nettype none
`include "forth_stack_execution_unit_macros.svh"
module forth_stack_execution_unit
   import fsx_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [5:0]        req_op,
   input  wire logic [CELL_W-1:0] req_literal,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CELL_W-1:0]      rsp_top_value,
   output logic [CNT_W-1:0]       rsp_data_count,
   output logic [CNT_W-1:0]       rsp_return_count,
   output logic [1:0]             rsp_status
);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_CHECK, S_EXEC, S_MUL, S_DIVA, S_DIVB, S_DIVI, S_DIVQ, S_DIVR,
      S_WRITE, S_TOPRD, S_TOPWT, S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [5:0]        op_ff, op_in;
   logic [CELL_W-1:0] lit_ff, lit_in;
   logic [CELL_W-1:0] x_ff [4];
   logic [CELL_W-1:0] x_in [4];
   logic [CELL_W-1:0] w_ff [4];
   logic [CELL_W-1:0] w_in [4];
   logic [2:0]        rcnt_ff, rcnt_in;
   logic [2:0]        wcnt_ff, wcnt_in;
   logic [2:0]        wj_ff, wj_in;
   logic [CNT_W-1:0]  d_ff, d_in, rd_ff, rd_in, nd_ff, nd_in, nrd_ff, nrd_in;
   status_type        st_ff, st_in;
   logic [CELL_W-1:0] acc_ff, acc_in, pa_ff, pa_in, pb_ff, pb_in, top_ff, top_in;
   logic [5:0]        it_ff, it_in;

   add_req_type       areq;
   logic [CELL_W+1:0] asum;

   logic              d_we, r_we;
   logic [CNT_W-1:0]  d_rptr, d_wptr, r_rptr;
   logic [ADDR_W-1:0] d_waddr, d_raddr, r_raddr, r_waddr;
   logic [CELL_W-1:0] d_wdata, d_rdata, r_rdata;

   logic [2:0]        need;
   logic signed [2:0] grow;
   logic [CNT_W-1:0]  grow_ext, nd_calc;
   logic [1:0]        cap_idx;
   logic [CELL_W:0]   shifted;
   logic              f_eq, f_lt, f_gt, f_z, f_n;

   fsx_alu u_alu (.req(areq), .sum(asum));

   fsx_ram #(.WIDTH(CELL_W), .DEPTH(STACK_CELLS)) u_data_ram (
      .clock(clock), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
      .rd_addr(d_raddr), .rd_data(d_rdata)
   );

   fsx_ram #(.WIDTH(CELL_W), .DEPTH(STACK_CELLS)) u_ret_ram (
      .clock(clock), .wr_en(r_we), .wr_addr(r_waddr), .wr_data(x_ff[0]),
      .rd_addr(r_raddr), .rd_data(r_rdata)
   );

   // read pointer walks down from the top while fetching operands
   assign d_rptr  = d_ff - CNT_W'(1) - ((state_ff == S_READ) ? CNT_W'(rcnt_ff) : '0);
   assign d_raddr = d_rptr[ADDR_W-1:0];
   assign d_wptr  = nd_ff - CNT_W'(1) - CNT_W'(wj_ff);
   assign d_waddr = d_wptr[ADDR_W-1:0];
   assign d_wdata = w_ff[wj_ff[1:0]];
   assign d_we    = (state_ff == S_WRITE) && (wj_ff < wcnt_ff);
   // return ram always presents its top cell
   assign r_rptr  = rd_ff - CNT_W'(1);
   assign r_raddr = r_rptr[ADDR_W-1:0];
   assign r_waddr = rd_ff[ADDR_W-1:0];
   assign r_we    = (state_ff == S_WRITE) && (wj_ff == 3'd0) && (op_ff == OP_TOR);

   assign need     = need_of(op_ff);
   assign grow     = (op_ff == OP_QDUP && x_ff[0] == '0) ? 3'sd0 : grow_of(op_ff);
   assign grow_ext = {{(CNT_W-3){grow[2]}}, grow};
   assign nd_calc  = d_ff + grow_ext;
   assign cap_idx  = rcnt_ff[1:0] - 2'd1;
   assign shifted  = {acc_ff, pa_ff[CELL_W-1]};

   assign f_eq = (x_ff[1] == x_ff[0]);
   assign f_lt = ($signed(x_ff[1]) < $signed(x_ff[0]));
   assign f_gt = ($signed(x_ff[0]) < $signed(x_ff[1]));
   assign f_z  = (x_ff[0] == '0);
   assign f_n  = x_ff[0][CELL_W-1];

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      lit_in   = lit_ff;
      x_in     = x_ff;
      w_in     = w_ff;
      rcnt_in  = rcnt_ff;
      wcnt_in  = wcnt_ff;
      wj_in    = wj_ff;
      d_in     = d_ff;
      rd_in    = rd_ff;
      nd_in    = nd_ff;
      nrd_in   = nrd_ff;
      st_in    = st_ff;
      acc_in   = acc_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      it_in    = it_ff;
      top_in   = top_ff;
      areq     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               lit_in   = req_literal;
               rcnt_in  = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (rcnt_ff != 3'd0) begin
               x_in[cap_idx] = d_rdata;
            end
            if (rcnt_ff == need) begin
               state_in = S_CHECK;
            end else begin
               rcnt_in = rcnt_ff + 3'd1;
            end
         end
         S_CHECK: begin
            nd_in  = nd_calc;
            nrd_in = rd_ff;
            if (op_ff == OP_TOR) begin
               nrd_in = rd_ff + CNT_W'(1);
            end else if (op_ff == OP_RFROM || op_ff == OP_RDROP) begin
               nrd_in = rd_ff - CNT_W'(1);
            end
            // checks in priority order
            if (d_ff < CNT_W'(need)) begin
               st_in = ST_UNDER;
            end else if ((op_ff == OP_RFROM || op_ff == OP_RDROP) && rd_ff == '0) begin
               st_in = ST_UNDER;
            end else if (!grow[2] && grow != 3'sd0 && nd_calc > CNT_W'(STACK_CELLS)) begin
               st_in = ST_OVER;
            end else if (op_ff == OP_TOR && rd_ff >= CNT_W'(STACK_CELLS)) begin
               st_in = ST_OVER;
            end else if (op_ff == OP_DIVMOD && f_z) begin
               st_in = ST_DIVZ;
            end else begin
               st_in = ST_OK;
            end
            acc_in = '0;
            pa_in  = x_ff[0];
            pb_in  = x_ff[1];
            it_in  = '0;
            wj_in  = '0;
            if (st_in != ST_OK) begin
               state_in = S_TOPRD;
            end else if (op_ff == OP_MUL) begin
               state_in = S_MUL;
            end else if (op_ff == OP_DIVMOD) begin
               state_in = S_DIVA;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            wcnt_in = 3'd1;
            case (op_ff)
               OP_INC:   areq = '{a: {1'b0, x_ff[0]}, b: (CELL_W+1)'(1), sub: 1'b0};
               OP_DEC:   areq = '{a: {1'b0, x_ff[0]}, b: (CELL_W+1)'(1), sub: 1'b1};
               OP_CELLP: areq = '{a: {1'b0, x_ff[0]}, b: (CELL_W+1)'(CELL_BYTES), sub: 1'b0};
               OP_CELLM: areq = '{a: {1'b0, x_ff[0]}, b: (CELL_W+1)'(CELL_BYTES), sub: 1'b1};
               OP_ADD:   areq = '{a: {1'b0, x_ff[1]}, b: {1'b0, x_ff[0]}, sub: 1'b0};
               OP_SUB:   areq = '{a: {1'b0, x_ff[1]}, b: {1'b0, x_ff[0]}, sub: 1'b1};
               default:  areq = '0;
            endcase
            case (op_ff)
               OP_SWAP: begin
                  w_in[0] = x_ff[1]; w_in[1] = x_ff[0]; wcnt_in = 3'd2;
               end
               OP_DUP:  w_in[0] = x_ff[0];
               OP_OVER: w_in[0] = x_ff[1];
               OP_ROT: begin
                  w_in[0] = x_ff[2]; w_in[1] = x_ff[0]; w_in[2] = x_ff[1]; wcnt_in = 3'd3;
               end
               OP_NROT: begin
                  w_in[0] = x_ff[1]; w_in[1] = x_ff[2]; w_in[2] = x_ff[0]; wcnt_in = 3'd3;
               end
               OP_2DUP: begin
                  w_in[0] = x_ff[0]; w_in[1] = x_ff[1]; wcnt_in = 3'd2;
               end
               OP_2SWAP: begin
                  w_in[0] = x_ff[2]; w_in[1] = x_ff[3];
                  w_in[2] = x_ff[0]; w_in[3] = x_ff[1]; wcnt_in = 3'd4;
               end
               OP_QDUP: begin
                  w_in[0] = x_ff[0];
                  wcnt_in = f_z ? 3'd0 : 3'd1;
               end
               OP_INC, OP_DEC, OP_CELLP, OP_CELLM, OP_ADD, OP_SUB:
                  w_in[0] = asum[CELL_W-1:0];
               OP_EQ:     w_in[0] = {CELL_W{f_eq}};
               OP_NE:     w_in[0] = {CELL_W{!f_eq}};
               OP_LT:     w_in[0] = {CELL_W{f_lt}};
               OP_GT:     w_in[0] = {CELL_W{f_gt}};
               OP_LE:     w_in[0] = {CELL_W{!f_gt}};
               OP_GE:     w_in[0] = {CELL_W{!f_lt}};
               OP_ZEQ:    w_in[0] = {CELL_W{f_z}};
               OP_ZNE:    w_in[0] = {CELL_W{!f_z}};
               OP_ZLT:    w_in[0] = {CELL_W{f_n}};
               OP_ZGT:    w_in[0] = {CELL_W{!f_n && !f_z}};
               OP_ZLE:    w_in[0] = {CELL_W{f_n || f_z}};
               OP_ZGE:    w_in[0] = {CELL_W{!f_n}};
               OP_AND:    w_in[0] = x_ff[1] & x_ff[0];
               OP_OR:     w_in[0] = x_ff[1] | x_ff[0];
               OP_XOR:    w_in[0] = x_ff[1] ^ x_ff[0];
               OP_INVERT: w_in[0] = ~x_ff[0];
               OP_LIT:    w_in[0] = lit_ff;
               OP_RFROM:  w_in[0] = r_rdata;
               default:   wcnt_in = 3'd0;
            endcase
            state_in = S_WRITE;
         end
         S_MUL: begin
            // shift-add, one multiplier bit per cycle
            areq   = '{a: {1'b0, acc_ff}, b: {1'b0, (pa_ff[0] ? pb_ff : '0)}, sub: 1'b0};
            acc_in = asum[CELL_W-1:0];
            pa_in  = pa_ff >> 1;
            pb_in  = pb_ff << 1;
            it_in  = it_ff + 6'd1;
            if (it_ff == 6'd63) begin
               w_in[0]  = asum[CELL_W-1:0];
               wcnt_in  = 3'd1;
               state_in = S_WRITE;
            end
         end
         S_DIVA: begin
            areq  = '{a: '0, b: {1'b0, x_ff[1]}, sub: 1'b1};
            pa_in = x_ff[1][CELL_W-1] ? asum[CELL_W-1:0] : x_ff[1];
            state_in = S_DIVB;
         end
         S_DIVB: begin
            areq   = '{a: '0, b: {1'b0, x_ff[0]}, sub: 1'b1};
            pb_in  = f_n ? asum[CELL_W-1:0] : x_ff[0];
            acc_in = '0;
            it_in  = '0;
            state_in = S_DIVI;
         end
         S_DIVI: begin
            // restoring divide on magnitudes, quotient shifts into pa
            areq = '{a: shifted, b: {1'b0, pb_ff}, sub: 1'b1};
            if (asum[CELL_W+1]) begin
               acc_in = asum[CELL_W-1:0];
               pa_in  = {pa_ff[CELL_W-2:0], 1'b1};
            end else begin
               acc_in = shifted[CELL_W-1:0];
               pa_in  = {pa_ff[CELL_W-2:0], 1'b0};
            end
            it_in = it_ff + 6'd1;
            if (it_ff == 6'd63) begin
               state_in = S_DIVQ;
            end
         end
         S_DIVQ: begin
            areq    = '{a: '0, b: {1'b0, pa_ff}, sub: 1'b1};
            w_in[0] = (x_ff[1][CELL_W-1] ^ f_n) ? asum[CELL_W-1:0] : pa_ff;
            state_in = S_DIVR;
         end
         S_DIVR: begin
            areq    = '{a: '0, b: {1'b0, acc_ff}, sub: 1'b1};
            w_in[1] = x_ff[1][CELL_W-1] ? asum[CELL_W-1:0] : acc_ff;
            wcnt_in = 3'd2;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (wj_ff < wcnt_ff) begin
               wj_in = wj_ff + 3'd1;
            end else begin
               d_in     = nd_ff;
               rd_in    = nrd_ff;
               state_in = S_TOPRD;
            end
         end
         S_TOPRD: begin
            state_in = S_TOPWT;
         end
         S_TOPWT: begin
            top_in   = (d_ff == '0) ? '0 : d_rdata;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         d_ff     <= '0;
         rd_ff    <= '0;
         st_ff    <= ST_OK;
      end else begin
         state_ff <= state_in;
         d_ff     <= d_in;
         rd_ff    <= rd_in;
         st_ff    <= st_in;
      end
      op_ff   <= op_in;
      lit_ff  <= lit_in;
      x_ff    <= x_in;
      w_ff    <= w_in;
      rcnt_ff <= rcnt_in;
      wcnt_ff <= wcnt_in;
      wj_ff   <= wj_in;
      nd_ff   <= nd_in;
      nrd_ff  <= nrd_in;
      acc_ff  <= acc_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      it_ff   <= it_in;
      top_ff  <= top_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = (state_ff == S_RESP);
   assign rsp_top_value    = top_ff;
   assign rsp_data_count   = d_ff;
   assign rsp_return_count = rd_ff;
   assign rsp_status       = st_ff;

   `FSX_ASSERT_NOW(a_depth_range, rsp_valid, (d_ff <= CNT_W'(STACK_CELLS)) && (rd_ff <= CNT_W'(STACK_CELLS)), "stack depth out of range")
   `FSX_ASSERT_NOW(a_write_only_ok, state_ff == S_WRITE, st_ff == ST_OK, "write-back after a failed check")
   `FSX_ASSERT_NOW(a_empty_top_zero, rsp_valid && rsp_data_count == '0, rsp_top_value == '0, "empty stack with nonzero top")
   `FSX_ASSERT_NEXT(a_accept_reads, state_ff == S_IDLE && req_valid, state_ff == S_READ, "accepted transaction did not start")
   `FSX_ASSERT_NOW(a_ram_write_phase, d_we || r_we, state_ff == S_WRITE, "stack ram written outside write-back")

endmodule
`default_nettype wire
